@@ rtl/hvt_pkg.sv @@
`default_nettype none

package hvt_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD_TRANS = 2'd0,
        MODE_LOAD_INIT  = 2'd1,
        MODE_LOAD_EMIT  = 2'd2,
        MODE_OBSERVE    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_MAX,
        ST_DONE
    } state_t;

    localparam logic signed [15:0] Q_MIN_LOG = 16'sh8000;
    localparam logic signed [33:0] SAT_HI    = 34'sd2147483647;
    localparam logic signed [33:0] SAT_LO    = -34'sd2147483648;

    // Q4.11 to Q16.16, widened for exact sums
    function automatic logic signed [33:0] q_to_wide(input logic signed [15:0] v);
        return {{13{v[15]}}, v, 5'b0};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < SAT_LO)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/hvt_cmd_if.sv @@
`default_nettype none

interface hvt_cmd_if;
    logic                valid;
    logic                ready;
    hvt_pkg::mode_t      mode;
    logic [3:0]          from_state;
    logic [3:0]          to_state;
    logic [11:0]         word_id;
    logic signed [15:0]  log_value;
    logic                first_word;

    modport source (
        output valid, mode, from_state, to_state, word_id, log_value, first_word,
        input  ready
    );
    modport sink (
        input  valid, mode, from_state, to_state, word_id, log_value, first_word,
        output ready
    );
    modport mon (
        input valid, ready, mode, from_state, to_state, word_id, log_value, first_word
    );
endinterface

`default_nettype wire

@@ rtl/hvt_res_if.sv @@
`default_nettype none

interface hvt_res_if;
    logic                valid;
    logic                ready;
    logic [3:0]          best_state;
    logic signed [31:0]  best_score;

    modport source (
        output valid, best_state, best_score,
        input  ready
    );
    modport sink (
        input  valid, best_state, best_score,
        output ready
    );
    modport mon (
        input valid, ready, best_state, best_score
    );
endinterface

`default_nettype wire

@@ rtl/hmm_viterbi_forward_tagger_unit.sv @@
// Load items: accepted while idle, ready again the next cycle, no result.
// Observe item: the single add-compare-select unit walks every
// source/destination pair, each destination once for a first word,
// then a serial argmax over the states.
// One item at a time; the result waits in an output register.
// Reset clears control and path scores; the tables are undefined until loaded.
`default_nettype none

module hmm_viterbi_forward_tagger_unit #(
    parameter int NUM_STATES = 10,
    parameter int NUM_WORDS  = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    hvt_cmd_if.sink      cmd,
    hvt_res_if.source    res
);

    localparam int SW     = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int TDEPTH = NUM_STATES * NUM_STATES;
    localparam int TA_W   = $clog2(TDEPTH);
    localparam int EDEPTH = NUM_WORDS * NUM_STATES;
    localparam int EA_W   = $clog2(EDEPTH);
    localparam logic [SW-1:0] LAST = SW'(NUM_STATES - 1);

    logic signed [15:0] trans_mem_reg [TDEPTH];
    logic signed [15:0] init_mem_reg  [NUM_STATES];
    logic signed [15:0] emit_mem_reg  [EDEPTH];
    logic signed [15:0] trans_rd_reg, init_rd_reg, emit_rd_reg;

    hvt_pkg::state_t    state_reg, state_next;
    logic [SW-1:0]      j_reg, j_next, k_reg, k_next, m_reg, m_next;
    logic               first_reg, first_next, oow_reg, oow_next;
    logic [EA_W-1:0]    base_reg, base_next;
    logic               d_valid_reg, d_valid_next, d_last_reg, d_last_next;
    logic [SW-1:0]      d_j_reg, d_j_next, d_k_reg, d_k_next;
    logic signed [33:0] best_reg, best_next;
    logic [SW-1:0]      bs_reg, bs_next;
    logic signed [31:0] bscore_reg, bscore_next;
    logic               out_valid_reg, out_valid_next;
    logic [3:0]         out_state_reg, out_state_next;
    logic signed [31:0] out_score_reg, out_score_next;
    logic signed [31:0] path_reg [NUM_STATES];
    logic signed [31:0] path_next [NUM_STATES];
    logic signed [31:0] scratch_reg [NUM_STATES];
    logic signed [31:0] scratch_next [NUM_STATES];

    logic               accept, from_ok, to_ok, word_ok;
    logic               trans_we, init_we, emit_we;
    logic [TA_W-1:0]    trans_wa, trans_ra;
    logic [EA_W-1:0]    emit_wa, emit_ra;
    logic               last_k;
    logic signed [33:0] emit_w, path_w, cand, new_best;
    logic               take;
    logic signed [31:0] max_cand;

    assign cmd.ready      = (state_reg == hvt_pkg::ST_IDLE);
    assign res.valid      = out_valid_reg;
    assign res.best_state = out_state_reg;
    assign res.best_score = out_score_reg;

    assign accept  = cmd.valid && cmd.ready;
    assign from_ok = {1'b0, cmd.from_state} < 5'(NUM_STATES);
    assign to_ok   = {1'b0, cmd.to_state} < 5'(NUM_STATES);
    assign word_ok = 32'(cmd.word_id) < 32'(NUM_WORDS);

    always_comb
    begin
        trans_we = 1'b0;
        init_we  = 1'b0;
        emit_we  = 1'b0;
        unique case (cmd.mode)
            hvt_pkg::MODE_LOAD_TRANS: trans_we = accept && from_ok && to_ok;
            hvt_pkg::MODE_LOAD_INIT:  init_we  = accept && to_ok;
            hvt_pkg::MODE_LOAD_EMIT:  emit_we  = accept && to_ok && word_ok;
            default:                  ;
        endcase
    end

    assign trans_wa = TA_W'(32'(cmd.from_state) * NUM_STATES + 32'(cmd.to_state));
    assign emit_wa  = EA_W'(32'(cmd.word_id) * NUM_STATES + 32'(cmd.to_state));
    assign trans_ra = TA_W'(32'(k_reg) * NUM_STATES + 32'(j_reg));
    assign emit_ra  = base_reg + EA_W'(j_reg);

    always_ff @(posedge clk)
    begin
        if (trans_we)
        begin
            trans_mem_reg[trans_wa] <= cmd.log_value;
        end
        trans_rd_reg <= trans_mem_reg[trans_ra];
    end

    always_ff @(posedge clk)
    begin
        if (init_we)
        begin
            init_mem_reg[cmd.to_state[SW-1:0]] <= cmd.log_value;
        end
        init_rd_reg <= init_mem_reg[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (emit_we)
        begin
            emit_mem_reg[emit_wa] <= cmd.log_value;
        end
        emit_rd_reg <= emit_mem_reg[emit_ra];
    end

    // add-compare-select on the read data
    assign emit_w   = oow_reg ? hvt_pkg::q_to_wide(hvt_pkg::Q_MIN_LOG)
                              : hvt_pkg::q_to_wide(emit_rd_reg);
    assign path_w   = 34'(path_reg[d_k_reg]);
    assign cand     = first_reg ? (hvt_pkg::q_to_wide(init_rd_reg) + emit_w)
                                : (path_w + hvt_pkg::q_to_wide(trans_rd_reg) + emit_w);
    assign take     = (d_k_reg == '0) || (cand > best_reg);
    assign new_best = take ? cand : best_reg;
    assign last_k   = first_reg || (k_reg == LAST);
    assign max_cand = scratch_reg[m_reg];

    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        first_next     = first_reg;
        oow_next       = oow_reg;
        base_next      = base_reg;
        d_valid_next   = 1'b0;
        d_last_next    = d_last_reg;
        d_j_next       = d_j_reg;
        d_k_next       = d_k_reg;
        best_next      = best_reg;
        bs_next        = bs_reg;
        bscore_next    = bscore_reg;
        out_valid_next = out_valid_reg;
        out_state_next = out_state_reg;
        out_score_next = out_score_reg;
        path_next      = path_reg;
        scratch_next   = scratch_reg;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (d_valid_reg)
        begin
            best_next = new_best;
            if (d_last_reg)
            begin
                scratch_next[d_j_reg] = hvt_pkg::sat32(new_best);
            end
        end

        unique case (state_reg)
            hvt_pkg::ST_IDLE:
            begin
                if (accept && cmd.mode == hvt_pkg::MODE_OBSERVE)
                begin
                    state_next = hvt_pkg::ST_RUN;
                    j_next     = '0;
                    k_next     = '0;
                    first_next = cmd.first_word;
                    oow_next   = !word_ok;
                    base_next  = EA_W'(32'(cmd.word_id) * NUM_STATES);
                end
            end
            hvt_pkg::ST_RUN:
            begin
                d_valid_next = 1'b1;
                d_j_next     = j_reg;
                d_k_next     = k_reg;
                d_last_next  = last_k;
                if (last_k)
                begin
                    k_next = '0;
                    if (j_reg == LAST)
                    begin
                        state_next = hvt_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            hvt_pkg::ST_DRAIN:
            begin
                state_next = hvt_pkg::ST_MAX;
                m_next     = '0;
            end
            hvt_pkg::ST_MAX:
            begin
                if (m_reg == '0)
                begin
                    path_next = scratch_reg;
                end
                if ((m_reg == '0) || (max_cand > bscore_reg))
                begin
                    bs_next     = m_reg;
                    bscore_next = max_cand;
                end
                if (m_reg == LAST)
                begin
                    state_next = hvt_pkg::ST_DONE;
                end
                else
                begin
                    m_next = m_reg + 1'b1;
                end
            end
            hvt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_state_next = 4'(bs_reg);
                    out_score_next = bscore_reg;
                    state_next     = hvt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hvt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hvt_pkg::ST_IDLE;
            j_reg         <= '0;
            k_reg         <= '0;
            m_reg         <= '0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_STATES; i++)
            begin
                path_reg[i]    <= '0;
                scratch_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            m_reg         <= m_next;
            d_valid_reg   <= d_valid_next;
            out_valid_reg <= out_valid_next;
            path_reg      <= path_next;
            scratch_reg   <= scratch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg     <= first_next;
        oow_reg       <= oow_next;
        base_reg      <= base_next;
        d_last_reg    <= d_last_next;
        d_j_reg       <= d_j_next;
        d_k_reg       <= d_k_next;
        best_reg      <= best_next;
        bs_reg        <= bs_next;
        bscore_reg    <= bscore_next;
        out_state_reg <= out_state_next;
        out_score_reg <= out_score_next;
    end

endmodule

`default_nettype wire

@@ rtl/hvt_checker.sv @@
`default_nettype none

module hvt_checker #(
    parameter int NUM_STATES = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    hvt_cmd_if.sink     cmd,
    hvt_res_if.source   res
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.best_state)
                                    && $stable(res.best_score))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.best_state <= 4'(NUM_STATES - 1))
        else $error("best_state out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready && cmd.mode == hvt_pkg::MODE_OBSERVE |=> !cmd.ready)
        else $error("ready while an observation is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready && cmd.mode != hvt_pkg::MODE_OBSERVE && !res.valid
        |=> !res.valid)
        else $error("load produced a result");

endmodule

bind hmm_viterbi_forward_tagger_unit hvt_checker #(
    .NUM_STATES (NUM_STATES)
) u_hvt_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .res   (res)
);

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTATE        = 10;
    localparam int NWORD         = 4096;
    localparam int RANDOM_ITEMS  = 220;
    localparam int EXTREME_STEPS = 24;
    localparam int DRAIN_CYCLES  = 150;
    localparam int LIMIT_NS      = 40_000_000;

    localparam logic signed [33:0] SCORE_HI = 34'sd2147483647;
    localparam logic signed [33:0] SCORE_LO = -34'sd2147483648;
    localparam logic [NSTATE-1:0]  ALL_STATES = '1;

    typedef struct packed {
        hvt_pkg::mode_t     mode;
        logic [3:0]         from_state;
        logic [3:0]         to_state;
        logic [11:0]        word_id;
        logic signed [15:0] log_value;
        logic               first_word;
    } tag_cmd_t;

    typedef struct packed {
        logic [3:0]         best_state;
        logic signed [31:0] best_score;
    } tag_result_t;

    logic clk = 1'b0;
    logic rst_n;

    hvt_cmd_if cmd_bus ();
    hvt_res_if res_bus ();

    hmm_viterbi_forward_tagger_unit #(
        .NUM_STATES(NSTATE),
        .NUM_WORDS (NWORD)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_bus),
        .res  (res_bus)
    );

    logic signed [15:0] trans_q  [NSTATE][NSTATE];
    logic signed [15:0] init_q   [NSTATE];
    logic signed [15:0] emit_q   [NWORD][NSTATE];
    logic [NSTATE-1:0]  emit_written [NWORD];
    logic signed [31:0] path_q   [NSTATE];
    int unsigned        word_pool [$];
    tag_result_t        expected_tags [$];
    int unsigned        mismatches;
    bit                 idling;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic signed [33:0] q411_to_q1616(input logic signed [15:0] v);
        logic signed [33:0] w;
        w = v;
        return w * 34'sd32;
    endfunction

    function automatic logic signed [31:0] clamp_score(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > SCORE_HI)
        begin
            r = SCORE_HI[31:0];
        end
        else if (v < SCORE_LO)
        begin
            r = SCORE_LO[31:0];
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic tag_result_t viterbi_step(input logic [11:0] word, input logic first);
        logic signed [33:0] e;
        logic signed [33:0] cand;
        logic signed [33:0] best;
        logic signed [31:0] next_path [NSTATE];
        tag_result_t        r;
        for (int j = 0; j < NSTATE; j++)
        begin
            e = q411_to_q1616(emit_q[word][j]);
            if (first)
            begin
                best = q411_to_q1616(init_q[j]) + e;
            end
            else
            begin
                best = '0;
                for (int k = 0; k < NSTATE; k++)
                begin
                    cand = path_q[k] + q411_to_q1616(trans_q[k][j]) + e;
                    if (k == 0 || cand > best)
                    begin
                        best = cand;
                    end
                end
            end
            next_path[j] = clamp_score(best);
        end
        r.best_state = '0;
        for (int j = 0; j < NSTATE; j++)
        begin
            path_q[j] = next_path[j];
            if (path_q[j] > path_q[r.best_state])
            begin
                r.best_state = 4'(j);
            end
        end
        r.best_score = path_q[r.best_state];
        return r;
    endfunction

    function automatic void apply_item(input tag_cmd_t it);
        case (it.mode)
            hvt_pkg::MODE_LOAD_TRANS:
            begin
                if (it.from_state < NSTATE && it.to_state < NSTATE)
                begin
                    trans_q[it.from_state][it.to_state] = it.log_value;
                end
            end
            hvt_pkg::MODE_LOAD_INIT:
            begin
                if (it.to_state < NSTATE)
                begin
                    init_q[it.to_state] = it.log_value;
                end
            end
            hvt_pkg::MODE_LOAD_EMIT:
            begin
                if (it.to_state < NSTATE)
                begin
                    emit_q[it.word_id][it.to_state] = it.log_value;
                    if (emit_written[it.word_id] != ALL_STATES)
                    begin
                        emit_written[it.word_id][it.to_state] = 1'b1;
                        if (emit_written[it.word_id] == ALL_STATES)
                        begin
                            word_pool = {word_pool, 32'(it.word_id)};
                        end
                    end
                end
            end
            default:
            begin
                expected_tags = {expected_tags, viterbi_step(it.word_id, it.first_word)};
            end
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idling)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] pick_log_value();
        logic signed [15:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'sh8000;
            1: v = 16'sd32767;
            2: v = 16'sd0;
            3: v = -16'sd2048;
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic tag_cmd_t make_load(input hvt_pkg::mode_t m, input int from_s,
                                           input int to_s, input int word,
                                           input logic signed [15:0] val);
        tag_cmd_t it;
        it.mode       = m;
        it.from_state = 4'(from_s);
        it.to_state   = 4'(to_s);
        it.word_id    = 12'(word);
        it.log_value  = val;
        it.first_word = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic tag_cmd_t make_observe(input int word, input logic first);
        tag_cmd_t it;
        it.mode       = hvt_pkg::MODE_OBSERVE;
        it.from_state = 4'($urandom_range(0, 15));
        it.to_state   = 4'($urandom_range(0, 15));
        it.word_id    = 12'(word);
        it.log_value  = 16'($urandom_range(0, 65535));
        it.first_word = first;
        return it;
    endfunction

    task automatic send_item(input tag_cmd_t it);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.mode       <= it.mode;
        cmd_bus.from_state <= it.from_state;
        cmd_bus.to_state   <= it.to_state;
        cmd_bus.word_id    <= it.word_id;
        cmd_bus.log_value  <= it.log_value;
        cmd_bus.first_word <= it.first_word;
        cmd_bus.valid      <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (cmd_bus.ready !== 1'b1);
        apply_item(it);
    endtask

    task automatic load_transitions(input bit random_values, input logic signed [15:0] fixed);
        for (int k = 0; k < NSTATE; k++)
        begin
            for (int j = 0; j < NSTATE; j++)
            begin
                send_item(make_load(hvt_pkg::MODE_LOAD_TRANS, k, j,
                                    $urandom_range(0, NWORD - 1),
                                    random_values ? pick_log_value() : fixed));
            end
        end
    endtask

    task automatic load_initials(input bit random_values, input logic signed [15:0] fixed);
        for (int j = 0; j < NSTATE; j++)
        begin
            send_item(make_load(hvt_pkg::MODE_LOAD_INIT, $urandom_range(0, 15), j,
                                $urandom_range(0, NWORD - 1),
                                random_values ? pick_log_value() : fixed));
        end
    endtask

    task automatic fill_word(input int word, input bit random_values,
                             input logic signed [15:0] fixed);
        for (int j = 0; j < NSTATE; j++)
        begin
            send_item(make_load(hvt_pkg::MODE_LOAD_EMIT, $urandom_range(0, 15), j, word,
                                random_values ? pick_log_value() : fixed));
        end
    endtask

    task automatic test_table_fill();
        load_transitions(1'b1, 16'sd0);
        load_initials(1'b1, 16'sd0);
        fill_word(0, 1'b0, 16'sh8000);
        fill_word(NWORD - 1, 1'b0, 16'sd32767);
        fill_word(12'hAAA, 1'b1, 16'sd0);
        fill_word(12'h555, 1'b1, 16'sd0);
    endtask

    task automatic test_observe_from_reset();
        send_item(make_observe(12'hAAA, 1'b0));
        send_item(make_observe(12'h555, 1'b0));
    endtask

    task automatic test_ignored_loads();
        send_item(make_load(hvt_pkg::MODE_LOAD_TRANS, 15, 0, 0, 16'sd32767));
        send_item(make_load(hvt_pkg::MODE_LOAD_TRANS, 10, 9, 0, 16'sh8000));
        send_item(make_load(hvt_pkg::MODE_LOAD_TRANS, 3, 12, 0, 16'sd32767));
        send_item(make_load(hvt_pkg::MODE_LOAD_INIT, 0, 10, 0, 16'sd32767));
        send_item(make_load(hvt_pkg::MODE_LOAD_INIT, 15, 15, 0, 16'sd32767));
        send_item(make_load(hvt_pkg::MODE_LOAD_EMIT, 0, 15, 5, 16'sd32767));
        send_item(make_load(hvt_pkg::MODE_LOAD_EMIT, 0, 11, 12'h555, 16'sd32767));
        send_item(make_observe(12'h555, 1'b0));
        send_item(make_observe(NWORD - 1, 1'b1));
    endtask

    task automatic test_sentence_extremes();
        send_item(make_observe(NWORD - 1, 1'b1));
        send_item(make_observe(0, 1'b0));
        send_item(make_observe(0, 1'b0));
        send_item(make_observe(NWORD - 1, 1'b0));
        send_item(make_observe(12'hAAA, 1'b1));
        send_item(make_observe(12'h555, 1'b0));
    endtask

    task automatic test_score_ties();
        load_initials(1'b0, 16'sd0);
        fill_word(12'h555, 1'b0, 16'sd0);
        send_item(make_observe(12'h555, 1'b1));
        load_transitions(1'b0, 16'sd0);
        send_item(make_observe(12'h555, 1'b0));
        send_item(make_load(hvt_pkg::MODE_LOAD_INIT, 0, 6, 0, 16'sd1000));
        send_item(make_load(hvt_pkg::MODE_LOAD_INIT, 0, 8, 0, 16'sd1000));
        send_item(make_observe(12'h555, 1'b1));
        send_item(make_observe(12'h555, 1'b0));
    endtask

    task automatic test_extreme_values();
        idling = 1'b0;
        load_transitions(1'b0, 16'sd32767);
        load_initials(1'b0, 16'sd32767);
        fill_word(7, 1'b0, 16'sd32767);
        send_item(make_observe(7, 1'b1));
        repeat (EXTREME_STEPS) send_item(make_observe(7, 1'b0));
        load_transitions(1'b0, 16'sh8000);
        load_initials(1'b0, 16'sh8000);
        fill_word(7, 1'b0, 16'sh8000);
        send_item(make_observe(7, 1'b1));
        repeat (EXTREME_STEPS) send_item(make_observe(7, 1'b0));
        idling = 1'b1;
    endtask

    task automatic test_random_traffic();
        int          sent;
        int          rounds;
        int unsigned r;
        int          word;
        sent   = 0;
        rounds = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (rounds % 80 == 0)
            begin
                idling = ($urandom_range(0, 3) != 0);
            end
            rounds++;
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                word = word_pool[$urandom_range(0, word_pool.size() - 1)];
                send_item(make_observe(word, $urandom_range(0, 5) == 0));
                sent++;
            end
            else if (r < 63)
            begin
                send_item(make_load(hvt_pkg::MODE_LOAD_TRANS, $urandom_range(0, NSTATE - 1),
                                    $urandom_range(0, NSTATE - 1),
                                    $urandom_range(0, NWORD - 1), pick_log_value()));
                sent++;
            end
            else if (r < 70)
            begin
                send_item(make_load(hvt_pkg::MODE_LOAD_INIT, $urandom_range(0, 15),
                                    $urandom_range(0, NSTATE - 1),
                                    $urandom_range(0, NWORD - 1), pick_log_value()));
                sent++;
            end
            else if (r < 80)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    word = word_pool[$urandom_range(0, word_pool.size() - 1)];
                end
                else
                begin
                    word = $urandom_range(0, NWORD - 1);
                end
                send_item(make_load(hvt_pkg::MODE_LOAD_EMIT, $urandom_range(0, 15),
                                    $urandom_range(0, NSTATE - 1), word, pick_log_value()));
                sent++;
            end
            else if (r < 88)
            begin
                fill_word($urandom_range(0, NWORD - 1), 1'b1, 16'sd0);
                sent += NSTATE;
            end
            else
            begin
                // out-of-range indices: the block drops these
                case ($urandom_range(0, 3))
                    0: send_item(make_load(hvt_pkg::MODE_LOAD_TRANS,
                                           $urandom_range(NSTATE, 15),
                                           $urandom_range(0, 15), 0, pick_log_value()));
                    1: send_item(make_load(hvt_pkg::MODE_LOAD_TRANS, $urandom_range(0, 15),
                                           $urandom_range(NSTATE, 15), 0, pick_log_value()));
                    2: send_item(make_load(hvt_pkg::MODE_LOAD_INIT, $urandom_range(0, 15),
                                           $urandom_range(NSTATE, 15), 0, pick_log_value()));
                    default: send_item(make_load(hvt_pkg::MODE_LOAD_EMIT,
                                                 $urandom_range(0, 15),
                                                 $urandom_range(NSTATE, 15),
                                                 $urandom_range(0, NWORD - 1),
                                                 pick_log_value()));
                endcase
                sent++;
            end
        end
    endtask

    task automatic check_result(input logic [3:0] state, input logic signed [31:0] score);
        tag_result_t want;
        if (expected_tags.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("result with no item waiting: state %0d score %0d", state, score);
            end
        end
        else
        begin
            want = expected_tags.pop_front();
            if (state !== want.best_state || score !== want.best_score)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: state exp %0d got %0d, score exp %0d got %0d",
                             want.best_state, state, want.best_score, score);
                end
            end
        end
    endtask

    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
            begin
                check_result(res_bus.best_state, res_bus.best_score);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                res_bus.ready <= (stall_left == 0);
            end
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        mismatches = 0;
        idling     = 1'b1;
        for (int w = 0; w < NWORD; w++)
        begin
            emit_written[w] = '0;
        end
        for (int j = 0; j < NSTATE; j++)
        begin
            path_q[j] = '0;
        end
        rst_n              <= 1'b0;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.mode       <= hvt_pkg::MODE_LOAD_TRANS;
        cmd_bus.from_state <= '0;
        cmd_bus.to_state   <= '0;
        cmd_bus.word_id    <= '0;
        cmd_bus.log_value  <= '0;
        cmd_bus.first_word <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_table_fill();
        test_observe_from_reset();
        test_ignored_loads();
        test_sentence_extremes();
        test_score_ties();
        test_extreme_values();
        test_random_traffic();

        cmd_bus.valid <= 1'b0;
        while (expected_tags.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_tags.size() == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/hvt_pkg.sv
rtl/hvt_cmd_if.sv
rtl/hvt_res_if.sv
rtl/hmm_viterbi_forward_tagger_unit.sv
rtl/hvt_checker.sv
tb/testbench.sv
